### rtl/core/ils_pkg.sv
package ils_pkg;

   localparam int ILS_CAPACITY = 16;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int LEN_W    = 5;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // per-cycle command to every cell in the row
   typedef struct packed {
      logic shift_up;    // open a slot at target, later entries move up
      logic shift_down;  // close the slot at target, later entries move down
   } cell_ctl_type;

endpackage

### rtl/core/indexed_list_store.sv
// Channel  Dir  tdata fields (low bit first)
// req_     in   command[2:0] item_value[34:3] position[39:35]
// rsp_     out  result_value[31:0] list_length[36:32] status[38:37]
//
// One command per cycle while req_tready is high: each transaction is
// resolved in the cycle it is accepted, with every cell of the entry row
// shifting in parallel. The result is captured in the output register at
// the accepting edge and offered on rsp_ from the next cycle.
// req_tready is high whenever the output register is empty or being drained.
// Synchronous reset empties the list; entry contents are not cleared.
module indexed_list_store
   import ils_pkg::*;
#(
   parameter int CAPACITY = ILS_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // command, item_value, position
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // result_value, list_length, status
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;
   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

   logic [CMD_W-1:0]          command;
   logic signed [VALUE_W-1:0] item_value;
   logic [POS_W-1:0]          position;

   assign command    = req_tdata[CMD_W-1:0];
   assign item_value = req_tdata[CMD_W+VALUE_W-1:CMD_W];
   assign position   = req_tdata[CMD_W+VALUE_W+POS_W-1:CMD_W+VALUE_W];

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   cell_ctl_type              ctl;
   logic [COUNT_W-1:0]        target;
   logic signed [VALUE_W-1:0] result_value;
   logic [STATUS_W-1:0]       status;
   logic                      take_sel;
   logic [CMP_W-1:0]          pos_ext;
   logic [CMP_W-1:0]          count_ext;
   logic                      full;
   logic                      empty;

   logic signed [VALUE_W-1:0] entry [CAPACITY];
   logic signed [VALUE_W-1:0] sel   [CAPACITY+1];

   assign pos_ext   = CMP_W'(position);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ff == CAP);
   assign empty     = (count_ff == '0);

   always_comb begin
      ctl.shift_up   = 1'b0;
      ctl.shift_down = 1'b0;
      target         = '0;
      status         = ST_OK;
      take_sel       = 1'b0;
      count_in       = count_ff;
      case (command)
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
            if (full) begin
               status = ST_FULL;
            end else if (command == CMD_INS_POS && pos_ext > count_ext) begin
               status = ST_RANGE;
            end else begin
               ctl.shift_up = accept;
               count_in     = count_ff + COUNT_W'(1);
               if (command == CMD_INS_TAIL) begin
                  target = count_ff;
               end else if (command == CMD_INS_POS) begin
                  target = COUNT_W'(pos_ext);
               end
            end
         end
         CMD_DEL_HEAD, CMD_DEL_TAIL: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               ctl.shift_down = accept;
               take_sel       = 1'b1;
               count_in       = count_ff - COUNT_W'(1);
               if (command == CMD_DEL_TAIL) begin
                  target = count_ff - COUNT_W'(1);
               end
            end
         end
         CMD_READ: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status = ST_RANGE;
            end else begin
               take_sel = 1'b1;
               target   = COUNT_W'(pos_ext);
            end
         end
         default: begin
         end
      endcase
   end

   assign sel[0] = '0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_entry;
      logic signed [VALUE_W-1:0] next_entry;

      if (k == 0) begin : g_first
         assign prev_entry = item_value;
      end else begin : g_mid
         assign prev_entry = entry[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign next_entry = entry[k];
      end else begin : g_inner
         assign next_entry = entry[k+1];
      end

      ils_cell #(
         .INDEX   (k),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .target     (target),
         .item_value (item_value),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .sel_in     (sel[k]),
         .entry_out  (entry[k]),
         .sel_out    (sel[k+1])
      );
   end

   assign result_value = take_sel ? sel[CAPACITY] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, status, LEN_W'(count_in), result_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/ils_cell.sv
module ils_cell
   import ils_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  logic                       clock,
   input  cell_ctl_type               ctl,
   input  logic [COUNT_W-1:0]         target,
   input  logic signed [VALUE_W-1:0]  item_value,
   input  logic signed [VALUE_W-1:0]  prev_entry,
   input  logic signed [VALUE_W-1:0]  next_entry,
   input  logic signed [VALUE_W-1:0]  sel_in,
   output logic signed [VALUE_W-1:0]  entry_out,
   output logic signed [VALUE_W-1:0]  sel_out
);

   localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      hit;
   logic                      above;

   assign hit   = (IDX == target);
   assign above = (IDX > target);

   always_comb begin
      if (ctl.shift_up && above) begin
         entry_in = prev_entry;
      end else if (ctl.shift_up && hit) begin
         entry_in = item_value;
      end else if (ctl.shift_down && (above || hit)) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // selected entry ripples along the row; only the target cell contributes
   assign sel_out   = hit ? (sel_in | entry_ff) : sel_in;
   assign entry_out = entry_ff;

endmodule

### dv/tb_indexed_list_store.sv
`timescale 1ns / 100ps

module tb_indexed_list_store;
   import ils_pkg::*;

   // codes the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS = 500;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [LEN_W-1:0]    length;
      logic [STATUS_W-1:0] status;
   } list_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      logic [4:0]         reps;
      logic               fixed;   // want holds a hand-written result
      list_result_type    want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // command, item_value, position
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // result_value, list_length, status

   logic [VALUE_W-1:0] list_entries [ILS_CAPACITY];
   int                 list_count = 0;
   list_result_type    pending_results [$];
   stim_row_type       directed_rows [$];
   int                 error_count = 0;
   int                 stall_cycles = 0;
   logic               steady = 1'b0;   // no idling on either side while set

   indexed_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // list predictor: updates the local copy and returns the result
   function automatic list_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                     logic [VALUE_W-1:0] value,
                                                     logic [POS_W-1:0] pos);
      list_result_type res;
      int              at;
      res = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
            at = (cmd == CMD_INS_HEAD) ? 0 : (cmd == CMD_INS_TAIL) ? list_count : int'(pos);
            if (list_count >= ILS_CAPACITY) begin
               res.status = ST_FULL;
            end else if (at > list_count) begin
               res.status = ST_RANGE;
            end else begin
               for (int k = list_count; k > at; k--) list_entries[k] = list_entries[k-1];
               list_entries[at] = value;
               list_count++;
            end
         end
         CMD_DEL_HEAD, CMD_DEL_TAIL: begin
            if (list_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               at = (cmd == CMD_DEL_HEAD) ? 0 : list_count - 1;
               res.value = list_entries[at];
               for (int k = at; k + 1 < list_count; k++) list_entries[k] = list_entries[k+1];
               list_count--;
            end
         end
         CMD_READ: begin
            if (list_count == 0)
               res.status = ST_EMPTY;
            else if (int'(pos) >= list_count)
               res.status = ST_RANGE;
            else
               res.value = list_entries[pos];
         end
         default: ;
      endcase
      res.length = list_count[LEN_W-1:0];
      return res;
   endfunction

   task automatic add_row(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                          logic [POS_W-1:0] pos, int reps, logic fixed,
                          logic [VALUE_W-1:0] want_value, int want_length,
                          logic [STATUS_W-1:0] want_status);
      stim_row_type row;
      row.cmd         = cmd;
      row.value       = value;
      row.pos         = pos;
      row.reps        = reps[4:0];
      row.fixed       = fixed;
      row.want.value  = want_value;
      row.want.length = want_length[LEN_W-1:0];
      row.want.status = want_status;
      directed_rows.push_back(row);
   endtask

   // present one transaction; the prediction is taken at the accepting edge
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos, logic fixed, list_result_type want);
      list_result_type pred;
      while (!steady && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, value, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = apply_command(cmd, value, pos);
      pending_results.push_back(fixed ? want : pred);
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 8);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      list_result_type got;
      list_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata[31:0];
         got.length = rsp_tdata[36:32];
         got.status = rsp_tdata[38:37];
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: value %h length %0d status %0d",
                     $time, got.value, got.length, got.status);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (got.value !== exp_res.value) begin
               $display("%0t: result_value expected %h actual %h",
                        $time, exp_res.value, got.value);
               error_count++;
            end
            if (got.length !== exp_res.length) begin
               $display("%0t: list_length expected %0d actual %0d",
                        $time, exp_res.length, got.length);
               error_count++;
            end
            if (got.status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_res.status, got.status);
               error_count++;
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("** indexed_list_store: FAILED **");
         $finish;
      end
   end

   initial begin
      stim_row_type       row;
      list_result_type    none;
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      int                 bias;
      int                 ins_pct;
      int                 roll;
      none = '0;

      // empty list, then a few inserts, reads at both ends and past the end, spare codes
      add_row(CMD_DEL_HEAD, 32'h1234_5678, 5'd0,  1, 1'b1, '0, 0, ST_EMPTY);
      add_row(CMD_DEL_TAIL, 32'hffff_ffff, 5'd31, 1, 1'b1, '0, 0, ST_EMPTY);
      add_row(CMD_READ,     32'h0,         5'd0,  1, 1'b1, '0, 0, ST_EMPTY);
      add_row(CMD_INS_POS,  32'hdead_beef, 5'd1,  1, 1'b1, '0, 0, ST_RANGE);
      add_row(CMD_INS_POS,  32'h0,         5'd0,  1, 1'b1, '0, 1, ST_OK);
      add_row(CMD_INS_HEAD, 32'h7fff_ffff, 5'd0,  1, 1'b1, '0, 2, ST_OK);
      add_row(CMD_INS_TAIL, 32'h8000_0000, 5'd16, 1, 1'b1, '0, 3, ST_OK);
      add_row(CMD_INS_POS,  32'hffff_ffff, 5'd3,  1, 1'b0, '0, 0, ST_OK);
      add_row(CMD_INS_POS,  32'h5a5a_a5a5, 5'd1,  1, 1'b0, '0, 0, ST_OK);
      add_row(CMD_READ,     32'h0,         5'd0,  1, 1'b1, 32'h7fff_ffff, 5, ST_OK);
      add_row(CMD_READ,     32'h0,         5'd4,  1, 1'b0, '0, 0, ST_OK);
      add_row(CMD_READ,     32'h0,         5'd5,  1, 1'b1, '0, 5, ST_RANGE);
      add_row(CMD_READ,     32'hffff_ffff, 5'd31, 1, 1'b1, '0, 5, ST_RANGE);
      add_row(CMD_SPARE_6,  32'hffff_ffff, 5'd31, 1, 1'b0, '0, 0, ST_OK);
      add_row(CMD_SPARE_7,  32'h0,         5'd16, 1, 1'b0, '0, 0, ST_OK);
      // fill to capacity, then every insert must report full; then drain to empty
      add_row(CMD_INS_TAIL, 32'ha5a5_0000, 5'd0,  11, 1'b0, '0, 0, ST_OK);
      add_row(CMD_INS_HEAD, 32'h1,         5'd0,  1, 1'b1, '0, 16, ST_FULL);
      add_row(CMD_INS_TAIL, 32'h2,         5'd0,  1, 1'b1, '0, 16, ST_FULL);
      add_row(CMD_INS_POS,  32'h3,         5'd31, 1, 1'b1, '0, 16, ST_FULL);
      add_row(CMD_READ,     32'h0,         5'd15, 1, 1'b0, '0, 0, ST_OK);
      add_row(CMD_READ,     32'h0,         5'd16, 1, 1'b1, '0, 16, ST_RANGE);
      add_row(CMD_DEL_TAIL, 32'h0,         5'd0,  1, 1'b0, '0, 0, ST_OK);
      add_row(CMD_DEL_HEAD, 32'h0,         5'd0,  1, 1'b1, 32'h7fff_ffff, 14, ST_OK);
      add_row(CMD_DEL_HEAD, 32'h0,         5'd0,  14, 1'b0, '0, 0, ST_OK);
      add_row(CMD_DEL_TAIL, 32'h0,         5'd0,  1, 1'b1, '0, 0, ST_EMPTY);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (int k = 0; k < row.reps; k++)
            send_command(row.cmd, row.value + VALUE_W'(k), row.pos, row.fixed, row.want);
      end

      bias = 1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swing between filling and draining so full and empty both recur
         if (n % 40 == 0) bias = $urandom_range(2);
         ins_pct = (bias == 2) ? 65 : (bias == 1) ? 40 : 20;
         steady = (n >= 150 && n < 250);
         if (n == 300) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         roll = $urandom_range(99);
         if (roll < 2)
            cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
         else if (roll < 2 + ins_pct)
            cmd = CMD_W'($urandom_range(2));     // one of the three inserts
         else if (roll < 22 + ins_pct)
            cmd = CMD_READ;
         else
            cmd = $urandom_range(1) ? CMD_DEL_TAIL : CMD_DEL_HEAD;
         case ($urandom_range(9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7fff_ffff;
            2:       value = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
            default: value = $urandom;
         endcase
         if ($urandom_range(9) == 0)
            pos = POS_W'($urandom_range(31));
         else
            pos = POS_W'($urandom_range(list_count));
         send_command(cmd, value, pos, 1'b0, none);
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** indexed_list_store: PASSED **");
      end else begin
         $display("** indexed_list_store: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/ils_pkg.sv
rtl/core/ils_cell.sv
rtl/core/indexed_list_store.sv
dv/tb_indexed_list_store.sv
